/* hw/rtl/lwp_pkg.sv */
package lwp_pkg;

    localparam int OPCODE_W   = 1;
    localparam int LOAD_IDX_W = 10;
    localparam int LOAD_VAL_W = 16;
    localparam int DAC_W      = 16;
    localparam int SIDX_W     = 10;
    localparam int CODE_W     = 12;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;
    localparam int LEN_W      = 11;
    localparam int IVAL_W     = 16;
    localparam int BPM_W      = 9;
    localparam int HALF_W     = 10;
    localparam int LEVEL_W    = 12;
    localparam int CNT_W      = 16;

    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = 4;

    localparam logic [DAC_W-1:0] RATE_NUMERATOR = 16'd60000;
    localparam logic [DAC_W-1:0] FRAME_CMD      = 16'h3000;

    localparam logic [OPCODE_W-1:0] OPC_LOAD = 1'b0;
    localparam logic [OPCODE_W-1:0] OPC_TICK = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RATE       = 2'd0;
    localparam int                MODE_SQUARE_BIT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_LENGTH   = 3'd1,
        CFG_INTERVAL = 3'd2,
        CFG_BPM      = 3'd3,
        CFG_HALF     = 3'd4,
        CFG_HIGH     = 3'd5,
        CFG_LOW      = 3'd6,
        CFG_ENABLE   = 3'd7
    } t_cfg_reg;

    typedef logic [3:0] t_step;

    localparam t_step S_FETCH    = 4'd0;
    localparam t_step S_DECODE   = 4'd1;
    localparam t_step S_LOAD     = 4'd2;
    localparam t_step S_TCLAMP   = 4'd3;
    localparam t_step S_TSTEP    = 4'd4;
    localparam t_step S_IDLECHK  = 4'd5;
    localparam t_step S_IDLE     = 4'd6;
    localparam t_step S_PASS     = 4'd7;
    localparam t_step S_DIVINIT  = 4'd8;
    localparam t_step S_DIVSTEP  = 4'd9;
    localparam t_step S_DIVEND   = 4'd10;
    localparam t_step S_EMIT     = 4'd11;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WRITE,
        OP_TCLAMP,
        OP_TSTEP,
        OP_IDLE,
        OP_READ,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_SETTARGET,
        OP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOREQ,
        C_LOAD,
        C_DISABLED,
        C_NOSLOT,
        C_NOTIDLE,
        C_NOTFIRST,
        C_NOTMODE0,
        C_DIVMORE,
        C_OUTFULL
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_step  jump;
        t_step  next;
    } t_uword;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, jump: S_FETCH, next: S_FETCH};
        case (step)
            S_FETCH:   w = '{op: OP_NOP,       cond: C_NOREQ,    jump: S_FETCH,   next: S_DECODE};
            S_DECODE:  w = '{op: OP_NOP,       cond: C_LOAD,     jump: S_LOAD,    next: S_TCLAMP};
            S_LOAD:    w = '{op: OP_WRITE,     cond: C_ALWAYS,   jump: S_FETCH,   next: S_FETCH};
            S_TCLAMP:  w = '{op: OP_TCLAMP,    cond: C_DISABLED, jump: S_FETCH,   next: S_TSTEP};
            S_TSTEP:   w = '{op: OP_TSTEP,     cond: C_NOSLOT,   jump: S_FETCH,   next: S_IDLECHK};
            S_IDLECHK: w = '{op: OP_NOP,       cond: C_NOTIDLE,  jump: S_PASS,    next: S_IDLE};
            S_IDLE:    w = '{op: OP_IDLE,      cond: C_ALWAYS,   jump: S_FETCH,   next: S_FETCH};
            S_PASS:    w = '{op: OP_READ,      cond: C_NOTFIRST, jump: S_EMIT,    next: S_DIVINIT};
            S_DIVINIT: w = '{op: OP_DIVINIT,   cond: C_NOTMODE0, jump: S_EMIT,    next: S_DIVSTEP};
            S_DIVSTEP: w = '{op: OP_DIVSTEP,   cond: C_DIVMORE,  jump: S_DIVSTEP, next: S_DIVEND};
            S_DIVEND:  w = '{op: OP_SETTARGET, cond: C_ALWAYS,   jump: S_EMIT,    next: S_EMIT};
            S_EMIT:    w = '{op: OP_EMIT,      cond: C_OUTFULL,  jump: S_EMIT,    next: S_FETCH};
            default:   w = '{op: OP_NOP,       cond: C_ALWAYS,   jump: S_FETCH,   next: S_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/lwp_ram.sv */
module lwp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/looped_waveform_player_dac.sv */
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_stall  i_opcode, i_load_index, i_load_value
// out       output     o_out_valid/i_out_stall o_dac_word, o_sample_index, o_last_of_wave
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A microcoded sequencer takes one request at a time and is busy from acceptance until it
// returns to its fetch step; loads, disabled ticks, ticks without a slot, idle slots and
// play slots each run through their own path of microcode steps.
// The first sample of a pass adds a divider-init step, and in table-with-rate mode also
// the divide steps, where the idle count comes from a one-bit-per-cycle restoring divider.
// Reset is synchronous; the wave memory has no reset and holds garbage until loaded.
// A finished result sits in the output register; the sequencer waits in its emit step
// only while that register is full and stalled.
module looped_waveform_player_dac #(
    parameter int WAVE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [lwp_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [lwp_pkg::LOAD_IDX_W-1:0]    i_load_index,
    input  logic [lwp_pkg::LOAD_VAL_W-1:0]    i_load_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lwp_pkg::DAC_W-1:0]         o_dac_word,
    output logic [lwp_pkg::SIDX_W-1:0]        o_sample_index,
    output logic                              o_last_of_wave,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lwp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lwp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import lwp_pkg::*;

    localparam int PW   = $clog2(WAVE_DEPTH);
    localparam int LENW = PW + 1;
    localparam int CW   = (LENW > 17) ? LENW : 17;
    localparam int HALF_DEPTH = WAVE_DEPTH / 2;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take;

    logic [MODE_W-1:0]  r_mode;
    logic [LEN_W-1:0]   r_wave_length;
    logic [IVAL_W-1:0]  r_interval;
    logic [BPM_W-1:0]   r_bpm;
    logic [HALF_W-1:0]  r_half_cfg;
    logic [LEVEL_W-1:0] r_high;
    logic [LEVEL_W-1:0] r_low;
    logic               r_enable;

    logic [OPCODE_W-1:0]   r_opcode;
    logic [LOAD_IDX_W-1:0] r_load_index;
    logic [CODE_W-1:0]     r_load_code;

    logic [IVAL_W-1:0] r_timer;
    logic [PW-1:0]     r_pos;
    logic              r_in_idle;
    logic [CNT_W-1:0]  r_idle_cnt;
    logic [CNT_W-1:0]  r_idle_tgt;

    logic [LENW-1:0]   r_len;
    logic [PW-1:0]     r_half;

    logic [DAC_W-1:0]     r_div_q;
    logic [BPM_W-1:0]     r_div_rem;
    logic [BPM_W-1:0]     r_div_d;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic               r_out_valid;
    logic [DAC_W-1:0]   r_dac_word;
    logic [SIDX_W-1:0]  r_sample_index;
    logic               r_last_of_wave;

    logic              accept;
    logic              cfg_we;
    logic              out_free;
    logic [IVAL_W-1:0] ival;
    logic [IVAL_W:0]   timer_inc;
    logic [CNT_W:0]    idle_inc;
    logic [CW-1:0]     load_ext;
    logic              mem_we;
    logic [CODE_W-1:0] rd_data;
    logic [CW-1:0]     half_ext;
    logic [CW-1:0]     half_eff;
    logic [CW-1:0]     wl_ext;
    logic [CW-1:0]     wl_eff;
    logic [CW-1:0]     len_w;
    logic [BPM_W:0]    div_trial;
    logic [BPM_W:0]    div_diff;
    logic              div_ge;
    logic [CW-1:0]     q_ext;
    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     tgt_w;
    logic [CW-1:0]     pos_ext;
    logic              last;
    logic [CODE_W-1:0] code;

    assign uw       = ucode_rom(r_step);
    assign accept   = i_in_valid && (r_step == S_FETCH);
    assign cfg_we   = i_cfg_valid && (r_step == S_FETCH);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (uw.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NOREQ:    take = !i_in_valid;
            C_LOAD:     take = (r_opcode == OPC_LOAD);
            C_DISABLED: take = !r_enable;
            C_NOSLOT:   take = (r_timer != '0);
            C_NOTIDLE:  take = !r_in_idle;
            C_NOTFIRST: take = (r_pos != '0);
            C_NOTMODE0: take = (r_mode != MODE_RATE);
            C_DIVMORE:  take = (r_div_cnt != '0);
            C_OUTFULL:  take = !out_free;
            default:    take = 1'b0;
        endcase
        n_step = take ? uw.jump : uw.next;
    end

    assign ival      = (r_interval == '0) ? IVAL_W'(1) : r_interval;
    assign timer_inc = {1'b0, r_timer} + (IVAL_W+1)'(1);
    assign idle_inc  = {1'b0, r_idle_cnt} + (CNT_W+1)'(1);

    assign load_ext = CW'(r_load_index);
    assign mem_we   = (uw.op == OP_WRITE) && (load_ext < CW'(WAVE_DEPTH));

    assign half_ext = CW'(r_half_cfg);
    assign half_eff = (half_ext == '0) ? CW'(1) :
                      (half_ext > CW'(HALF_DEPTH)) ? CW'(HALF_DEPTH) : half_ext;
    assign wl_ext   = CW'(r_wave_length);
    assign wl_eff   = (wl_ext == '0) ? CW'(1) :
                      (wl_ext > CW'(WAVE_DEPTH)) ? CW'(WAVE_DEPTH) : wl_ext;
    assign len_w    = r_mode[MODE_SQUARE_BIT] ? (half_eff << 1) : wl_eff;

    assign div_trial = {r_div_rem, r_div_q[DAC_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_div_d};
    assign div_diff  = div_trial - {1'b0, r_div_d};

    assign q_ext   = CW'(r_div_q);
    assign len_ext = CW'(r_len);
    assign tgt_w   = (q_ext > len_ext) ? (q_ext - len_ext) : '0;

    assign pos_ext = CW'(r_pos);
    assign last    = (pos_ext + CW'(1)) >= len_ext;
    assign code    = r_mode[MODE_SQUARE_BIT] ? ((r_pos < r_half) ? r_high : r_low) : rd_data;

    lwp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (WAVE_DEPTH)
    ) u_wave_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (load_ext[PW-1:0]),
        .i_wr_data (r_load_code),
        .i_rd_en   (uw.op == OP_READ),
        .i_rd_addr (r_pos),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= S_FETCH;
            r_mode        <= MODE_RATE;
            r_wave_length <= LEN_W'(1024);
            r_interval    <= IVAL_W'(1000);
            r_bpm         <= BPM_W'(60);
            r_half_cfg    <= HALF_W'(1);
            r_high        <= '0;
            r_low         <= '0;
            r_enable      <= 1'b1;
            r_timer       <= '0;
            r_pos         <= '0;
            r_in_idle     <= 1'b0;
            r_idle_cnt    <= '0;
            r_idle_tgt    <= '0;
            r_div_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_step <= n_step;
            if ((uw.op == OP_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (uw.op)
                OP_TCLAMP: begin
                    if (!r_enable) begin
                        r_timer    <= '0;
                        r_pos      <= '0;
                        r_in_idle  <= 1'b0;
                        r_idle_cnt <= '0;
                        r_idle_tgt <= '0;
                    end else if (r_timer >= ival) begin
                        r_timer <= '0;
                    end
                end
                OP_TSTEP: begin
                    r_timer <= (timer_inc >= {1'b0, ival}) ? '0 : timer_inc[IVAL_W-1:0];
                end
                OP_IDLE: begin
                    if (idle_inc >= {1'b0, r_idle_tgt}) begin
                        r_in_idle  <= 1'b0;
                        r_idle_cnt <= '0;
                        r_pos      <= '0;
                    end else begin
                        r_idle_cnt <= idle_inc[CNT_W-1:0];
                    end
                end
                OP_DIVINIT: begin
                    r_div_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
                    if (r_mode != MODE_RATE) begin
                        r_idle_tgt <= '0;
                    end
                end
                OP_DIVSTEP: begin
                    r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                end
                OP_SETTARGET: begin
                    r_idle_tgt <= tgt_w[CNT_W-1:0];
                end
                OP_EMIT: begin
                    if (out_free) begin
                        if (last) begin
                            r_pos      <= '0;
                            r_idle_cnt <= '0;
                            r_in_idle  <= (r_idle_tgt != '0);
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:     r_mode        <= i_cfg_data[MODE_W-1:0];
                    CFG_LENGTH:   r_wave_length <= i_cfg_data[LEN_W-1:0];
                    CFG_INTERVAL: r_interval    <= i_cfg_data[IVAL_W-1:0];
                    CFG_BPM:      r_bpm         <= i_cfg_data[BPM_W-1:0];
                    CFG_HALF:     r_half_cfg    <= i_cfg_data[HALF_W-1:0];
                    CFG_HIGH:     r_high        <= i_cfg_data[LEVEL_W-1:0];
                    CFG_LOW:      r_low         <= i_cfg_data[LEVEL_W-1:0];
                    CFG_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        if (!i_cfg_data[0]) begin
                            r_timer    <= '0;
                            r_pos      <= '0;
                            r_in_idle  <= 1'b0;
                            r_idle_cnt <= '0;
                            r_idle_tgt <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode     <= i_opcode;
            r_load_index <= i_load_index;
            r_load_code  <= i_load_value[CODE_W-1:0];
        end
        if (uw.op == OP_READ) begin
            r_len  <= len_w[LENW-1:0];
            r_half <= half_eff[PW-1:0];
        end
        if (uw.op == OP_DIVINIT) begin
            r_div_q   <= RATE_NUMERATOR;
            r_div_rem <= '0;
            r_div_d   <= (r_bpm == '0) ? BPM_W'(1) : r_bpm;
        end
        if (uw.op == OP_DIVSTEP) begin
            r_div_rem <= div_ge ? div_diff[BPM_W-1:0] : div_trial[BPM_W-1:0];
            r_div_q   <= {r_div_q[DAC_W-2:0], div_ge};
        end
        if ((uw.op == OP_EMIT) && out_free) begin
            r_dac_word     <= FRAME_CMD | DAC_W'(code);
            r_sample_index <= pos_ext[SIDX_W-1:0];
            r_last_of_wave <= last;
        end
    end

    assign o_in_stall     = (r_step != S_FETCH);
    assign o_cfg_ready    = (r_step == S_FETCH);
    assign o_out_valid    = r_out_valid;
    assign o_dac_word     = r_dac_word;
    assign o_sample_index = r_sample_index;
    assign o_last_of_wave = r_last_of_wave;

endmodule

/* hw/rtl/lwp_checker.sv */
module lwp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [lwp_pkg::OPCODE_W-1:0]      i_opcode,
    input logic [lwp_pkg::LOAD_IDX_W-1:0]    i_load_index,
    input logic [lwp_pkg::LOAD_VAL_W-1:0]    i_load_value,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [lwp_pkg::DAC_W-1:0]         o_dac_word,
    input logic [lwp_pkg::SIDX_W-1:0]        o_sample_index,
    input logic                              o_last_of_wave,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [lwp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [lwp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import lwp_pkg::*;

    // Configuration is taken only when the sequencer can take a new request.
    a_cfg_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_in_stall)
        else $error("config ready and input stall disagree");

    // A request is worked on before the next one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a request");

    // A result appears only while a request is in work.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in work");

    a_frame_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dac_word[DAC_W-1:CODE_W] == FRAME_CMD[DAC_W-1:CODE_W]))
        else $error("DAC frame command bits wrong");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_dac_word) && $stable(o_sample_index)
         && $stable(o_last_of_wave)))
        else $error("stalled result changed");

endmodule

bind looped_waveform_player_dac lwp_checker u_lwp_checker (.*);
